### rtl/ipv6u_pkg.sv
// shared constants, codes and types for the ipv6/udp header field extractor
package ipv6u_pkg;

    // header geometry
    localparam int HDR_KEEP     = 48;
    localparam int IPV6_HDR_LEN = 40;
    localparam int UDP_HDR_LEN  = 8;
    localparam int UDP_END      = IPV6_HDR_LEN + UDP_HDR_LEN;
    localparam int CNT_W        = 6;
    localparam logic [7:0] NH_UDP = 8'd17;

    // default depth of the header queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // field ids
    localparam logic [3:0] FID_VERSION  = 4'd0;
    localparam logic [3:0] FID_CLASS    = 4'd1;
    localparam logic [3:0] FID_FLOW     = 4'd2;
    localparam logic [3:0] FID_PAYLEN   = 4'd3;
    localparam logic [3:0] FID_NEXTHDR  = 4'd4;
    localparam logic [3:0] FID_HOPLIM   = 4'd5;
    localparam logic [3:0] FID_DEV_PFX  = 4'd6;
    localparam logic [3:0] FID_DEV_IID  = 4'd7;
    localparam logic [3:0] FID_APP_PFX  = 4'd8;
    localparam logic [3:0] FID_APP_IID  = 4'd9;
    localparam logic [3:0] FID_DEV_PORT = 4'd10;
    localparam logic [3:0] FID_APP_PORT = 4'd11;
    localparam logic [3:0] FID_UDP_LEN  = 4'd12;
    localparam logic [3:0] FID_UDP_CSUM = 4'd13;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT_IP  = 2'd1;
    localparam logic [1:0] ST_SHORT_UDP = 2'd2;

    // packet class decided by the front
    typedef enum logic [1:0] {
        KIND_OK_IP,
        KIND_OK_UDP,
        KIND_ERR_IP,
        KIND_ERR_UDP
    } t_kind;

    typedef logic [HDR_KEEP-1:0][7:0] t_hdr;

    // one finished packet header handed from front to back
    typedef struct packed {
        t_kind kind;
        logic  dir;
        t_hdr  hdr;
    } t_job;

endpackage

### rtl/ipv6u_if.sv
// valid/ready channel interfaces for packet bytes and extracted fields
interface ipv6u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       uplink;
    logic       last_byte;

    modport source (output valid, data_byte, uplink, last_byte, input ready);
    modport sink   (input valid, data_byte, uplink, last_byte, output ready);
endinterface

interface ipv6u_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_id;
    logic [63:0] field_value;
    logic [6:0]  field_bits;
    logic [1:0]  status;
    logic        last_field;

    modport source (output valid, field_id, field_value, field_bits, status, last_field,
                    input ready);
    modport sink   (input valid, field_id, field_value, field_bits, status, last_field,
                    output ready);
endinterface

### rtl/ipv6u_front.sv
// byte capture: stores the first header bytes, counts, classifies the packet
module ipv6u_front
    import ipv6u_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipv6u_in_if.sink     i_in,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output t_job         o_push_job
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dir;
    t_hdr             r_hdr, n_hdr;
    logic             w_accept;
    logic             w_cur_dir;
    logic             w_udp;

    // a non-last byte never needs queue room
    assign i_in.ready = i_push_ready || !i_in.last_byte;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cur_dir  = (r_count == '0) ? i_in.uplink : r_dir;

    // header bank with the current byte merged in
    always_comb begin
        n_hdr   = r_hdr;
        n_count = r_count;
        if (r_count < CNT_W'(HDR_KEEP)) begin
            n_hdr[r_count] = i_in.data_byte;
            n_count        = r_count + 1'b1;
        end
    end

    // packet classification on the last byte
    assign w_udp = (n_hdr[6] == NH_UDP);

    always_comb begin
        o_push_job.dir = w_cur_dir;
        o_push_job.hdr = n_hdr;
        if (n_count < CNT_W'(IPV6_HDR_LEN)) begin
            o_push_job.kind = KIND_ERR_IP;
        end else if (w_udp && n_count < CNT_W'(UDP_END)) begin
            o_push_job.kind = KIND_ERR_UDP;
        end else if (w_udp) begin
            o_push_job.kind = KIND_OK_UDP;
        end else begin
            o_push_job.kind = KIND_OK_IP;
        end
    end

    assign o_push_valid = w_accept && i_in.last_byte;

    // count and direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dir   <= 1'b0;
        end else if (w_accept) begin
            r_dir   <= w_cur_dir;
            r_count <= i_in.last_byte ? '0 : n_count;
        end
    end

    // header bytes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

### rtl/ipv6u_queue.sv
// short fifo of finished packet headers between front and back
module ipv6u_queue
    import ipv6u_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_head_valid,
    output t_job o_head_job,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [OCC_W-1:0] r_occ;
    logic             w_push;

    assign o_push_ready = (r_occ != OCC_W'(DEPTH));
    assign o_head_valid = (r_occ != '0);
    assign o_head_job   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_occ <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_occ <= r_occ + 1'b1;
            end else if (!w_push && i_pop) begin
                r_occ <= r_occ - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

### rtl/ipv6u_back.sv
// field sequencer: walks the head header and registers one field per transaction
module ipv6u_back
    import ipv6u_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_head_valid,
    input  t_job         i_head_job,
    output logic         o_pop,
    ipv6u_out_if.source  o_out
);

    logic [3:0]  r_idx;
    logic        r_valid;
    logic [3:0]  r_id;
    logic [63:0] r_value;
    logic [6:0]  r_blen;
    logic [1:0]  r_status;
    logic        r_last;

    logic [3:0]  n_id;
    logic [63:0] n_value;
    logic [6:0]  n_blen;
    logic [1:0]  n_status;
    logic        n_last;
    logic        w_load;
    logic        w_err;
    t_hdr        w_hdr;
    logic        w_dir;
    logic [63:0] w_pfx_s, w_iid_s, w_pfx_d, w_iid_d;
    logic [15:0] w_port_s, w_port_d;

    // big-endian 64-bit word from a fixed byte offset
    function automatic logic [63:0] be64(input t_hdr hdr, input logic [CNT_W-1:0] start);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < 8; k++) begin
            v[(7-k)*8 +: 8] = hdr[start + CNT_W'(k)];
        end
        return v;
    endfunction

    assign w_hdr    = i_head_job.hdr;
    assign w_dir    = i_head_job.dir;
    assign w_err    = (i_head_job.kind == KIND_ERR_IP) || (i_head_job.kind == KIND_ERR_UDP);
    assign w_pfx_s  = be64(w_hdr, CNT_W'(8));
    assign w_iid_s  = be64(w_hdr, CNT_W'(16));
    assign w_pfx_d  = be64(w_hdr, CNT_W'(24));
    assign w_iid_d  = be64(w_hdr, CNT_W'(32));
    assign w_port_s = {w_hdr[40], w_hdr[41]};
    assign w_port_d = {w_hdr[42], w_hdr[43]};

    // field select
    always_comb begin
        n_id     = r_idx;
        n_value  = '0;
        n_blen   = '0;
        n_status = ST_OK;
        n_last   = 1'b0;
        if (w_err) begin
            n_id     = FID_VERSION;
            n_status = (i_head_job.kind == KIND_ERR_IP) ? ST_SHORT_IP : ST_SHORT_UDP;
            n_last   = 1'b1;
        end else begin
            case (r_idx)
                FID_VERSION: begin
                    n_value = {60'd0, w_hdr[0][7:4]};
                    n_blen  = 7'd4;
                end
                FID_CLASS: begin
                    n_value = {56'd0, w_hdr[0][3:0], w_hdr[1][7:4]};
                    n_blen  = 7'd8;
                end
                FID_FLOW: begin
                    n_value = {44'd0, w_hdr[1][3:0], w_hdr[2], w_hdr[3]};
                    n_blen  = 7'd20;
                end
                FID_PAYLEN: begin
                    n_value = {48'd0, w_hdr[4], w_hdr[5]};
                    n_blen  = 7'd16;
                end
                FID_NEXTHDR: begin
                    n_value = {56'd0, w_hdr[6]};
                    n_blen  = 7'd8;
                end
                FID_HOPLIM: begin
                    n_value = {56'd0, w_hdr[7]};
                    n_blen  = 7'd8;
                end
                FID_DEV_PFX: begin
                    n_value = w_dir ? w_pfx_s : w_pfx_d;
                    n_blen  = 7'd64;
                end
                FID_DEV_IID: begin
                    n_value = w_dir ? w_iid_s : w_iid_d;
                    n_blen  = 7'd64;
                end
                FID_APP_PFX: begin
                    n_value = w_dir ? w_pfx_d : w_pfx_s;
                    n_blen  = 7'd64;
                end
                FID_APP_IID: begin
                    n_value = w_dir ? w_iid_d : w_iid_s;
                    n_blen  = 7'd64;
                    n_last  = (i_head_job.kind == KIND_OK_IP);
                end
                FID_DEV_PORT: begin
                    n_value = {48'd0, w_dir ? w_port_s : w_port_d};
                    n_blen  = 7'd16;
                end
                FID_APP_PORT: begin
                    n_value = {48'd0, w_dir ? w_port_d : w_port_s};
                    n_blen  = 7'd16;
                end
                FID_UDP_LEN: begin
                    n_value = {48'd0, w_hdr[44], w_hdr[45]};
                    n_blen  = 7'd16;
                end
                FID_UDP_CSUM: begin
                    n_value = {48'd0, w_hdr[46], w_hdr[47]};
                    n_blen  = 7'd16;
                    n_last  = 1'b1;
                end
                default: begin
                    n_last = 1'b1;
                end
            endcase
        end
    end

    // output register loads when a header is waiting and the register is empty or being drained
    assign w_load = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop  = w_load && n_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= FID_VERSION;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= n_last ? FID_VERSION : r_idx + 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_id     <= n_id;
            r_value  <= n_value;
            r_blen   <= n_blen;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.field_id    = r_id;
    assign o_out.field_value = r_value;
    assign o_out.field_bits  = r_blen;
    assign o_out.status      = r_status;
    assign o_out.last_field  = r_last;

endmodule

### rtl/ipv6_udp_header_field_extractor.sv
// IPv6/UDP header field extractor. Packet bytes enter one per cycle in network
// order; the first 48 are kept and the byte count saturates at 48. On the last
// byte the captured header is classified and pushed into a queue of
// QUEUE_DEPTH headers; the field sequencer then emits one result per cycle
// while the output is ready: 10 fields for plain IPv6, 14 with UDP, or a
// single status result for a short packet. Byte intake runs at one byte per
// cycle and overlaps emission of earlier packets; it stalls only on a last
// byte finding a full queue. Results leave through a registered output stage.
module ipv6_udp_header_field_extractor
    import ipv6u_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipv6u_in_if.sink    i_in,
    ipv6u_out_if.source o_out
);

    logic w_push_valid;
    logic w_push_ready;
    t_job w_push_job;
    logic w_head_valid;
    t_job w_head_job;
    logic w_pop;

    // byte capture and classification
    ipv6u_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    // header queue
    ipv6u_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_head_valid (w_head_valid),
        .o_head_job   (w_head_job),
        .i_pop        (w_pop)
    );

    // field sequencer
    ipv6u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head_job   (w_head_job),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

    // an error result is always marked as the last of its packet
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> o_out.last_field)
        else $error("error result without last_field");

    // zero length exactly on error results
    a_len_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.field_bits == 7'd0) == (o_out.status != ST_OK)))
        else $error("field_bits and status disagree");

    // retiring a header leaves its final result in the output register
    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_out.valid && o_out.last_field))
        else $error("header retired without a final result");

endmodule
